// File: src/cqc_pkg.sv
// Shared types, constants and the color tensor lookup for the contraction unit.
// Used by the top level, cqc_store, cqc_seq and cqc_mac. Depends on nothing.
package cqc_pkg;

	localparam int DEF_FRAC_BITS = 20;
	localparam int VEC_DEPTH     = 12;
	localparam int PROP_DEPTH    = 144;
	localparam int INT_DEPTH     = 9;
	localparam int ENT_W         = 48;   // {im, re}, Q4.20 each
	localparam int PART_W        = 24;
	localparam int INT_W         = 32;
	localparam int OUT_W         = 48;
	localparam int PROD_W        = INT_W + PART_W;
	localparam int ACC_W         = 64;

	typedef enum logic [1:0] {
		REQ_VEC  = 2'd0,
		REQ_P1   = 2'd1,
		REQ_P2   = 2'd2,
		REQ_COMP = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_P1,
		ST_WAIT,
		ST_P2,
		ST_FLUSH
	} state_t;

	// Control that travels with one complex product down the pipeline.
	typedef struct packed {
		logic       vld;
		logic       ph2;
		logic       first;
		logic       last;
		logic       neg;
		logic [3:0] dest;
		logic [7:0] oidx;
		logic       olast;
	} ctl_t;

	typedef struct packed {
		logic [1:0] u;
		logic [1:0] w;
		logic       neg;
	} eps_t;

	// The two permutations whose fixed slot holds color x; j picks one.
	// The same pairs serve both contractions.
	function automatic eps_t eps_pick(input logic [1:0] x, input logic j);
		eps_t e;
		e = '{u: 2'd0, w: 2'd1, neg: 1'b0};
		case ({x, j})
			3'b000:  e = '{u: 2'd1, w: 2'd2, neg: 1'b0};
			3'b001:  e = '{u: 2'd2, w: 2'd1, neg: 1'b1};
			3'b010:  e = '{u: 2'd0, w: 2'd2, neg: 1'b1};
			3'b011:  e = '{u: 2'd2, w: 2'd0, neg: 1'b0};
			3'b100:  e = '{u: 2'd0, w: 2'd1, neg: 1'b0};
			3'b101:  e = '{u: 2'd1, w: 2'd0, neg: 1'b1};
			default: e = '{u: 2'd0, w: 2'd1, neg: 1'b0};
		endcase
		return e;
	endfunction

endpackage

// File: src/color_epsilon_quark_contraction_unit.sv
// Baryon color-epsilon contraction unit: top level with the result register.
// Depends on cqc_pkg, cqc_store, cqc_seq and cqc_mac.
//
// Usage: requests arrive on the s_axis channel. tuser carries the request
// kind (load vector entry, load first propagator entry, load second
// propagator entry, compute). A load request is written when it is taken and
// gives no result. A compute request names a spin row and yields 48 complex
// results on m_axis in index order; tlast marks the 48th.
// Timing: one complex multiplier pair array does one complex product per
// cycle while the output is not stalled. The intermediate row takes 72
// products, then the pipeline drains before the 288 products of the second
// contraction, so a compute request occupies the block until they drain.
// s_axis_tready is high only while no compute is in progress.
// Reset clears the sequencer, the pipeline valids and the intermediate row;
// the entry memories keep whatever they held and must be loaded before use.
// When the receiver holds m_axis_tready low with a result waiting, the whole
// pipeline stalls and resumes without loss.
module color_epsilon_quark_contraction_unit #(
	parameter int FRAC_BITS = cqc_pkg::DEF_FRAC_BITS
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [63:0]  s_axis_tdata,  // elem_index[7:0], value_re[31:8], value_im[55:32], spin_row[57:56]
	input  logic [1:0]   s_axis_tuser,  // req_type[1:0]
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [103:0] m_axis_tdata,  // out_index[7:0], out_re[55:8], out_im[103:56]
	output logic         m_axis_tlast   // last_result
);
	import cqc_pkg::*;

	logic             acc_in, adv, start, busy, idle;
	req_t             req;
	ctl_t             ctl_s0;
	logic [3:0]       vec_addr;
	logic [7:0]       p1_addr, p2_addr;
	logic [ENT_W-1:0] vec_rd, p1_rd, p2_rd;
	logic             res_vld, res_last;
	logic [7:0]       res_idx;
	logic [OUT_W-1:0] res_re, res_im;
	logic             out_vld_q, out_last_q;
	logic [7:0]       out_idx_q;
	logic [OUT_W-1:0] out_re_q, out_im_q;

	assign req           = req_t'(s_axis_tuser);
	assign s_axis_tready = idle;
	assign acc_in        = s_axis_tvalid && s_axis_tready;
	assign start         = acc_in && req == REQ_COMP;
	assign adv           = !out_vld_q || m_axis_tready;

	cqc_store u_store (
		.clk      (clk),
		.wr_en    (acc_in && req != REQ_COMP),
		.wr_sel   (req),
		.wr_idx   (s_axis_tdata[7:0]),
		.wr_data  ({s_axis_tdata[55:32], s_axis_tdata[31:8]}),
		.adv      (adv),
		.vec_addr (vec_addr),
		.p1_addr  (p1_addr),
		.p2_addr  (p2_addr),
		.vec_rd   (vec_rd),
		.p1_rd    (p1_rd),
		.p2_rd    (p2_rd)
	);

	cqc_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.row      (s_axis_tdata[57:56]),
		.adv      (adv),
		.busy     (busy),
		.idle     (idle),
		.ctl      (ctl_s0),
		.vec_addr (vec_addr),
		.p1_addr  (p1_addr),
		.p2_addr  (p2_addr)
	);

	cqc_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.ctl_s0   (ctl_s0),
		.vec_rd   (vec_rd),
		.p1_rd    (p1_rd),
		.p2_rd    (p2_rd),
		.busy     (busy),
		.res_vld  (res_vld),
		.res_idx  (res_idx),
		.res_re   (res_re),
		.res_im   (res_im),
		.res_last (res_last)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= res_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_vld) begin
			out_idx_q  <= res_idx;
			out_re_q   <= res_re;
			out_im_q   <= res_im;
			out_last_q <= res_last;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {out_im_q, out_re_q, out_idx_q};
	assign m_axis_tlast  = out_last_q;

endmodule

// File: src/cqc_store.sv
// Entry memories: quark vector and both propagators, synchronous read.
// Depends on cqc_pkg.
module cqc_store (
	input  logic                       clk,
	input  logic                       wr_en,
	input  cqc_pkg::req_t              wr_sel,
	input  logic [7:0]                 wr_idx,
	input  logic [cqc_pkg::ENT_W-1:0]  wr_data,
	input  logic                       adv,
	input  logic [3:0]                 vec_addr,
	input  logic [7:0]                 p1_addr,
	input  logic [7:0]                 p2_addr,
	output logic [cqc_pkg::ENT_W-1:0]  vec_rd,
	output logic [cqc_pkg::ENT_W-1:0]  p1_rd,
	output logic [cqc_pkg::ENT_W-1:0]  p2_rd
);
	import cqc_pkg::*;

	logic [ENT_W-1:0] vec_mem [VEC_DEPTH];
	logic [ENT_W-1:0] p1_mem  [PROP_DEPTH];
	logic [ENT_W-1:0] p2_mem  [PROP_DEPTH];

	// Loads beyond the store depth are dropped.
	always_ff @(posedge clk) begin
		if (wr_en && wr_sel == REQ_VEC && wr_idx < 8'(VEC_DEPTH)) begin
			vec_mem[wr_idx[3:0]] <= wr_data;
		end
		if (wr_en && wr_sel == REQ_P1 && wr_idx < 8'(PROP_DEPTH)) begin
			p1_mem[wr_idx] <= wr_data;
		end
		if (wr_en && wr_sel == REQ_P2 && wr_idx < 8'(PROP_DEPTH)) begin
			p2_mem[wr_idx] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			vec_rd <= vec_mem[vec_addr];
			p1_rd  <= p1_mem[p1_addr];
			p2_rd  <= p2_mem[p2_addr];
		end
	end

endmodule

// File: src/cqc_seq.sv
// Sequencer: walks both contractions, one complex product a cycle while adv is high.
// Depends on cqc_pkg.
module cqc_seq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [1:0]    row,
	input  logic          adv,
	input  logic          busy,
	output logic          idle,
	output cqc_pkg::ctl_t ctl,
	output logic [3:0]    vec_addr,
	output logic [7:0]    p1_addr,
	output logic [7:0]    p2_addr
);
	import cqc_pkg::*;

	state_t     state_q, state_nx;
	logic [1:0] row_q;
	logic [1:0] x_q, y_q, z_q, w_q;
	logic       j_q;
	logic       lst, fst, fin;
	eps_t       e;
	logic [7:0] x8, y8, z8, w8, r8, u8, v8;

	assign x8 = {6'd0, x_q};
	assign y8 = {6'd0, y_q};
	assign z8 = {6'd0, z_q};
	assign w8 = {6'd0, w_q};
	assign r8 = {6'd0, row_q};
	assign u8 = {6'd0, e.u};
	assign v8 = {6'd0, e.w};

	// Phase one: x=a, y=m, z=s. Phase two: x=s2, y=s3, z=n, w=a.
	always_comb begin
		e   = eps_pick((state_q == ST_P2) ? z_q : x_q, j_q);
		fst = 1'b0;
		lst = 1'b0;
		fin = 1'b0;
		ctl = '0;
		vec_addr = '0;
		p1_addr  = '0;
		p2_addr  = '0;
		case (state_q)
			ST_P1: begin
				fst = (z_q == 2'd0) && !j_q;
				lst = (z_q == 2'd3) && j_q;
				fin = lst && x_q == 2'd2 && y_q == 2'd2;
				vec_addr = 4'(z8 * 8'd3 + u8);
				p1_addr  = ((r8 * 8'd3 + y8) * 8'd4 + z8) * 8'd3 + v8;
				ctl = '{vld: 1'b1, ph2: 1'b0, first: fst, last: lst, neg: e.neg,
					dest: 4'(x8 * 8'd3 + y8), oidx: 8'd0, olast: 1'b0};
			end
			ST_P2: begin
				fst = (w_q == 2'd0) && !j_q;
				lst = (w_q == 2'd2) && j_q;
				fin = lst && x_q == 2'd3 && y_q == 2'd3 && z_q == 2'd2;
				p2_addr = ((y8 * 8'd3 + v8) * 8'd4 + x8) * 8'd3 + w8;
				ctl = '{vld: 1'b1, ph2: 1'b1, first: fst, last: lst, neg: e.neg,
					dest: 4'(w8 * 8'd3 + u8),
					oidx: ((r8 * 8'd4 + x8) * 8'd4 + y8) * 8'd3 + z8, olast: fin};
			end
			default: begin
				ctl = '0;
			end
		endcase
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE:  if (start) state_nx = ST_P1;
			ST_P1:    if (adv && fin) state_nx = ST_WAIT;
			ST_WAIT:  if (!busy) state_nx = ST_P2;
			ST_P2:    if (adv && fin) state_nx = ST_FLUSH;
			ST_FLUSH: if (!busy) state_nx = ST_IDLE;
			default:  state_nx = ST_IDLE;
		endcase
	end

	assign idle = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			row_q   <= '0;
			x_q <= '0; y_q <= '0; z_q <= '0; w_q <= '0; j_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == ST_IDLE || state_q == ST_WAIT) begin
				x_q <= '0; y_q <= '0; z_q <= '0; w_q <= '0; j_q <= 1'b0;
				if (start && state_q == ST_IDLE) row_q <= row;
			end else if (adv && state_q == ST_P1) begin
				j_q <= !j_q;
				if (j_q) begin
					z_q <= z_q + 2'd1;
					if (z_q == 2'd3) begin
						y_q <= (y_q == 2'd2) ? 2'd0 : y_q + 2'd1;
						if (y_q == 2'd2) x_q <= x_q + 2'd1;
					end
				end
			end else if (adv && state_q == ST_P2) begin
				j_q <= !j_q;
				if (j_q) begin
					w_q <= (w_q == 2'd2) ? 2'd0 : w_q + 2'd1;
					if (w_q == 2'd2) begin
						z_q <= (z_q == 2'd2) ? 2'd0 : z_q + 2'd1;
						if (z_q == 2'd2) begin
							y_q <= y_q + 2'd1;
							if (y_q == 2'd3) x_q <= x_q + 2'd1;
						end
					end
				end
			end
		end
	end

endmodule

// File: src/cqc_mac.sv
// Complex multiply-accumulate pipeline, rounding, and the intermediate row.
// Depends on cqc_pkg.
module cqc_mac #(
	parameter int FRAC_BITS = cqc_pkg::DEF_FRAC_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        adv,
	input  cqc_pkg::ctl_t               ctl_s0,
	input  logic [cqc_pkg::ENT_W-1:0]   vec_rd,
	input  logic [cqc_pkg::ENT_W-1:0]   p1_rd,
	input  logic [cqc_pkg::ENT_W-1:0]   p2_rd,
	output logic                        busy,
	output logic                        res_vld,
	output logic [7:0]                  res_idx,
	output logic [cqc_pkg::OUT_W-1:0]   res_re,
	output logic [cqc_pkg::OUT_W-1:0]   res_im,
	output logic                        res_last
);
	import cqc_pkg::*;

	localparam logic signed [ACC_W-1:0] HALF  = ACC_W'(1) <<< (FRAC_BITS - 1);
	localparam logic signed [ACC_W-1:0] MAX48 = (ACC_W'(1) <<< (OUT_W - 1)) - 1;
	localparam logic signed [ACC_W-1:0] MIN48 = -MAX48 - 1;
	localparam logic signed [ACC_W-1:0] MAX32 = (ACC_W'(1) <<< (INT_W - 1)) - 1;
	localparam logic signed [ACC_W-1:0] MIN32 = -MAX32 - 1;

	ctl_t ctl_s1, ctl_s2, ctl_s3;
	logic [INT_W-1:0] int_re_q [INT_DEPTH];
	logic [INT_W-1:0] int_im_q [INT_DEPTH];
	logic signed [INT_W-1:0]  ia_re_s1, ia_im_s1, a_re, a_im;
	logic signed [PART_W-1:0] b_re, b_im;
	logic signed [PROD_W-1:0] rr_s2, ii_s2, ri_s2, ir_s2;
	logic signed [ACC_W-1:0]  t_re, t_im, n_re, n_im, acc_re_q, acc_im_q;
	logic signed [ACC_W-1:0]  fin_re_s3, fin_im_s3, rd_re, rd_im;
	logic signed [ACC_W-1:0]  s_re, s_im;
	logic                     fin_v;

	always_comb begin
		if (ctl_s1.ph2) begin
			a_re = ia_re_s1;
			a_im = ia_im_s1;
			b_re = p2_rd[PART_W-1:0];
			b_im = p2_rd[ENT_W-1:PART_W];
		end else begin
			a_re = INT_W'($signed(vec_rd[PART_W-1:0]));
			a_im = INT_W'($signed(vec_rd[ENT_W-1:PART_W]));
			b_re = p1_rd[PART_W-1:0];
			b_im = p1_rd[ENT_W-1:PART_W];
		end
	end

	always_comb begin
		t_re = ACC_W'(rr_s2) - ACC_W'(ii_s2);
		t_im = ACC_W'(ri_s2) + ACC_W'(ir_s2);
		if (ctl_s2.neg) begin
			t_re = -t_re;
			t_im = -t_im;
		end
		n_re = (ctl_s2.first ? '0 : acc_re_q) + t_re;
		n_im = (ctl_s2.first ? '0 : acc_im_q) + t_im;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else if (adv) begin
			ctl_s1 <= ctl_s0;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= (ctl_s2.vld && ctl_s2.last) ? ctl_s2 : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ia_re_s1  <= int_re_q[ctl_s0.dest];
			ia_im_s1  <= int_im_q[ctl_s0.dest];
			rr_s2     <= a_re * b_re;
			ii_s2     <= a_im * b_im;
			ri_s2     <= a_re * b_im;
			ir_s2     <= a_im * b_re;
			if (ctl_s2.vld) begin
				acc_re_q <= n_re;
				acc_im_q <= n_im;
			end
			fin_re_s3 <= n_re;
			fin_im_s3 <= n_im;
		end
	end

	// Round half up to FRAC_BITS fraction bits, then saturate.
	assign rd_re = (fin_re_s3 + HALF) >>> FRAC_BITS;
	assign rd_im = (fin_im_s3 + HALF) >>> FRAC_BITS;
	assign fin_v = ctl_s3.vld;

	always_comb begin
		if (ctl_s3.ph2) begin
			s_re = (rd_re > MAX48) ? MAX48 : (rd_re < MIN48) ? MIN48 : rd_re;
			s_im = (rd_im > MAX48) ? MAX48 : (rd_im < MIN48) ? MIN48 : rd_im;
		end else begin
			s_re = (rd_re > MAX32) ? MAX32 : (rd_re < MIN32) ? MIN32 : rd_re;
			s_im = (rd_im > MAX32) ? MAX32 : (rd_im < MIN32) ? MIN32 : rd_im;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < INT_DEPTH; i++) begin
				int_re_q[i] <= '0;
				int_im_q[i] <= '0;
			end
		end else if (adv && fin_v && !ctl_s3.ph2) begin
			int_re_q[ctl_s3.dest] <= s_re[INT_W-1:0];
			int_im_q[ctl_s3.dest] <= s_im[INT_W-1:0];
		end
	end

	assign busy     = ctl_s1.vld || ctl_s2.vld || fin_v;
	assign res_vld  = fin_v && ctl_s3.ph2;
	assign res_idx  = ctl_s3.oidx;
	assign res_re   = s_re[OUT_W-1:0];
	assign res_im   = s_im[OUT_W-1:0];
	assign res_last = ctl_s3.olast;

endmodule

// File: src/cqc_checker.sv
// Port-level checks for the contraction unit, bound to the top level.
// Depends on color_epsilon_quark_contraction_unit.
module cqc_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [103:0] m_axis_tdata,
	input logic         m_axis_tlast
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// The marked result is always the final index of a row.
	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |->
			m_axis_tdata[7:0] == 8'd47 || m_axis_tdata[7:0] == 8'd95 ||
			m_axis_tdata[7:0] == 8'd143 || m_axis_tdata[7:0] == 8'd191)
		else $error("last flag on a wrong index");

	// No new request is taken in a cycle that hands over a result other than the last of a run.
	a_busy_in: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast |-> !s_axis_tready)
		else $error("request taken in the middle of a run");

endmodule

bind color_epsilon_quark_contraction_unit cqc_checker u_cqc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);
